>>> hw/rtl/bwum_pkg.sv
// ----------------------------------------------------------------------------
// Busy-window utilisation meter package
// Widths, constants and the time type shared across the meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwum_pkg;

  localparam int unsigned TimeBits    = 48;
  localparam int unsigned WinBits     = 15;
  localparam int unsigned PctBits     = 7;
  localparam int unsigned MsBits      = 11;
  localparam int unsigned ProdBits    = 22;   // window span times one hundred
  localparam int unsigned DsrBits     = WinBits + PctBits - 1;
  localparam int unsigned StepCntBits = 3;

  localparam logic [WinBits-1:0] WindowReset = WinBits'(5000);
  localparam logic [PctBits-1:0] FullPct     = PctBits'(100);
  localparam logic [MsBits-1:0]  ReportMs    = MsBits'(1000);

  // floor(w / 1000) == (w * MsRecip) >> MsShift for every 15-bit w
  localparam int unsigned MsShift   = 25;
  localparam int unsigned RecipBits = 16;
  localparam logic [RecipBits-1:0] MsRecip = RecipBits'(33555);
  localparam int unsigned MsStepBits = 6;

  localparam logic [StepCntBits-1:0] LastStep = StepCntBits'(PctBits - 1);

  typedef logic [TimeBits-1:0] time_t;

endpackage

`default_nettype wire

>>> hw/rtl/bwum_divider.sv
// ----------------------------------------------------------------------------
// Percent divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwum_divider (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [bwum_pkg::ProdBits-1:0] dividend_i,
  input  wire [bwum_pkg::WinBits-1:0]  divisor_i,
  output logic                         done_o,
  output logic [bwum_pkg::PctBits-1:0] quotient_o
);
  import bwum_pkg::*;

  logic                   busy_q;
  logic [StepCntBits-1:0] cnt_q;
  logic [ProdBits-1:0]    rem_q;
  logic [DsrBits-1:0]     dsr_q;
  logic [PctBits-1:0]     quot_q;
  logic                   done_q;

  logic                   fits;
  logic [ProdBits-1:0]    diff;

  // shared compare/subtract unit
  assign fits = rem_q >= {1'b0, dsr_q};
  assign diff = rem_q - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      // flag done for one cycle after the last pass
      done_q <= busy_q && !start_i && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + StepCntBits'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= {divisor_i, (PctBits-1)'(0)};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff;
      end
      dsr_q  <= dsr_q >> 1;
      quot_q <= {quot_q[PctBits-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/busy_window_utilization_meter.sv
// ----------------------------------------------------------------------------
// Busy-window utilisation meter
// Percent of each sampling window covered by the last busy interval, with a
// halving running average and a one-second report flag.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tdata: busy_start, busy_end,
//                                         tick_end; tuser: busy_active
//  m_axis    out  tvalid / tready         tdata: window_usage, average_usage;
//                                         tuser: report_due
//  cfg       in   cfg_valid_i/cfg_ready_o cfg_wdata_i: window_us
//
//  An item holds the block from the accepting edge until it is back in idle.
//  When the busy interval misses the window, fully covers it or leaves no
//  overlap, the item passes through window start, clip, span and update.
//  A divide adds scale and launch after span and a divide wait before
//  update: seven passes of the shared subtractor, then a step to see done.
//  The update step writes the result once the output register is free.
//  Input ready is low from acceptance until the result is written to the
//  output register; a full output register stalls the update step.
//  Reset clears the average, the millisecond count and window_us to 5000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module busy_window_utilization_meter (
  input  wire          clk_i,
  input  wire          rst_ni,
  // configuration
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [14:0]  cfg_wdata_i,    // window_us
  // input items
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [143:0] s_axis_tdata,   // busy_start, busy_end, tick_end
  input  wire  [0:0]   s_axis_tuser,   // busy_active
  // result items
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // window_usage, average_usage, 2 pad
  output logic [0:0]   m_axis_tuser    // report_due
);
  import bwum_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StWstart = 3'd1;
  localparam logic [2:0] StClip   = 3'd2;
  localparam logic [2:0] StSpan   = 3'd3;
  localparam logic [2:0] StScale  = 3'd4;
  localparam logic [2:0] StLaunch = 3'd5;
  localparam logic [2:0] StDiv    = 3'd6;
  localparam logic [2:0] StUpdate = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [WinBits-1:0]    win_q;
  time_t                 bstart_q, bend_q, wend_q, wstart_q, lo_q, hi_q;
  logic                  none_q, full_q;
  logic [WinBits-1:0]    span_q;
  logic [ProdBits-1:0]   prod_q;
  logic [PctBits-1:0]    usage_q;
  logic [MsStepBits-1:0] ms_step_q;
  logic [PctBits-1:0]    avg_q, avg_d;
  logic [MsBits-1:0]     elapsed_q, elapsed_sum;
  logic                  out_valid_q;
  logic [PctBits-1:0]    out_usage_q, out_avg_q;
  logic                  out_report_q;

  logic                  accept, out_free, update_fire, report;
  logic                  div_start, div_done;
  logic [PctBits-1:0]    div_quot;
  logic [WinBits+RecipBits-1:0] ms_prod;
  logic [PctBits:0]      avg_sum;
  time_t                 win_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign update_fire   = (state_q == StUpdate) && out_free;
  assign div_start     = (state_q == StLaunch);
  assign win_ext       = {{(TimeBits-WinBits){1'b0}}, win_q};
  assign ms_prod       = win_q * MsRecip;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StWstart;
      StWstart: state_d = StClip;
      StClip:   state_d = StSpan;
      StSpan: begin
        if (none_q || full_q || (hi_q <= lo_q)) state_d = StUpdate;
        else                                    state_d = StScale;
      end
      StScale:  state_d = StLaunch;
      StLaunch: state_d = StDiv;
      StDiv:    if (div_done) state_d = StUpdate;
      StUpdate: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      win_q   <= WindowReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) win_q <= cfg_wdata_i;
    end
  end

  // Window arithmetic, one step per state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          bstart_q <= s_axis_tdata[47:0];
          bend_q   <= s_axis_tuser[0] ? s_axis_tdata[143:96] : s_axis_tdata[95:48];
          wend_q   <= s_axis_tdata[143:96];
        end
      end
      StWstart: begin
        // clamp the window start at time zero
        wstart_q  <= (wend_q > win_ext) ? (wend_q - win_ext) : '0;
        ms_step_q <= ms_prod[MsShift +: MsStepBits];
      end
      StClip: begin
        none_q <= (bstart_q >= wend_q) || (bend_q <= wstart_q);
        full_q <= (bstart_q <= wstart_q) && (bend_q >= wend_q);
        lo_q   <= (bstart_q > wstart_q) ? bstart_q : wstart_q;
        hi_q   <= (bend_q < wend_q) ? bend_q : wend_q;
      end
      StSpan: begin
        span_q <= WinBits'(hi_q - lo_q);
        if (none_q)              usage_q <= '0;
        else if (full_q)         usage_q <= FullPct;
        else                     usage_q <= '0;
      end
      StScale: begin
        // times one hundred: 64 + 32 + 4
        prod_q <= ({7'b0, span_q} << 6) + ({7'b0, span_q} << 5) + ({7'b0, span_q} << 2);
      end
      StDiv: begin
        if (div_done) usage_q <= (div_quot > FullPct) ? FullPct : div_quot;
      end
      default: ;
    endcase
  end

  bwum_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Running average and millisecond count
  assign avg_sum     = {1'b0, avg_q} + {1'b0, usage_q};
  assign avg_d       = ((avg_q == '0) && (usage_q != '0)) ? usage_q : avg_sum[PctBits:1];
  assign elapsed_sum = elapsed_q + {{(MsBits-MsStepBits){1'b0}}, ms_step_q};
  assign report      = elapsed_sum >= ReportMs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q        <= '0;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
      out_report_q <= 1'b0;
    end else begin
      if (update_fire) begin
        // drop average and count after a report
        avg_q        <= report ? '0 : avg_d;
        elapsed_q    <= report ? '0 : elapsed_sum;
        out_valid_q  <= 1'b1;
        out_report_q <= report;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_fire) begin
      out_usage_q <= usage_q;
      out_avg_q   <= avg_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {2'b00, out_avg_q, out_usage_q};
  assign m_axis_tuser[0] = out_report_q;

  // Checks
  a_usage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_usage_q <= FullPct && out_avg_q <= FullPct))
    else $error("result percent out of range");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_fire && report) |=> (avg_q == '0 && elapsed_q == '0))
    else $error("state not cleared after report");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (win_q != '0))
    else $error("divide launched with zero window");

  a_div_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside its wait step");

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Busy-window utilisation meter testbench
// Drives sampling ticks through the input stream, writes window_us between
// phases and checks each result against a cycle-free model or a table entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import bwum_pkg::*;

  localparam time_t       MaxStamp     = {TimeBits{1'b1}};
  localparam int unsigned SettleCycles = 20;      // outlasts a divide item
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SegItems     = 100;
  localparam int unsigned SegCount     = 18;
  localparam int unsigned DirRows      = 17;

  // One result item as the meter reports it
  typedef struct packed {
    logic [PctBits-1:0] usage;
    logic [PctBits-1:0] average;
    logic               report;
  } tick_result_t;

  // One row of the directed table; a row may first set a new window length
  typedef struct packed {
    logic               set_win;
    logic [WinBits-1:0] win;
    time_t              bstart;
    time_t              bend;
    logic               active;
    time_t              wend;
    logic               typed;
    tick_result_t       want;
  } tick_row_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [WinBits-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [143:0]       s_axis_tdata  = '0;  // busy_start, busy_end, tick_end
  logic [0:0]         s_axis_tuser  = '0;  // busy_active
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;        // window_usage, average_usage, 2 pad
  logic [0:0]         m_axis_tuser;        // report_due

  // Model state: window length, halving average, millisecond count
  logic [WinBits-1:0] model_win;
  logic [PctBits-1:0] model_avg;
  logic [MsBits-1:0]  model_ms;

  tick_result_t pending_results[$];
  int unsigned  mismatches    = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  tick_row_t directed_rows [DirRows];

  busy_window_utilization_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Percent of the window [wend - win, wend] covered by [bs, be]
  function automatic logic [PctBits-1:0] busy_percent(time_t bs, time_t be, time_t we,
                                                      logic [WinBits-1:0] win);
    logic [63:0] ws, lo, hi, pct;
    ws = (64'(we) > 64'(win)) ? 64'(we) - 64'(win) : 64'd0;
    if (bs >= we) return '0;
    if (64'(be) <= ws) return '0;
    if (64'(bs) <= ws && be >= we) return FullPct;
    lo = (64'(bs) > ws) ? 64'(bs) : ws;
    hi = (be < we) ? 64'(be) : 64'(we);
    if (hi <= lo || win == '0) return '0;
    pct = ((hi - lo) * 64'd100) / 64'(win);
    if (pct > 64'(FullPct)) pct = 64'(FullPct);
    return pct[PctBits-1:0];
  endfunction

  // Advance the model by one accepted tick and return what the meter must emit
  function automatic tick_result_t meter_tick(time_t bs, time_t be, logic act, time_t we);
    tick_result_t res;
    time_t        busy_to;
    busy_to   = act ? we : be;
    model_ms  = model_ms + MsBits'(model_win / 1000);
    res.usage = busy_percent(bs, busy_to, we, model_win);
    if (model_avg == '0 && res.usage != '0) begin
      model_avg = res.usage;
    end else begin
      model_avg = PctBits'((8'(model_avg) + 8'(res.usage)) >> 1);
    end
    res.average = model_avg;
    res.report  = 1'b0;
    if (model_ms >= ReportMs) begin
      res.report = 1'b1;
      model_ms   = '0;
      model_avg  = '0;
    end
    return res;
  endfunction

  // Offer one tick, idling first at the current sender rate; hold until taken
  task automatic send_tick(time_t bs, time_t be, logic act, time_t we, logic typed,
                           tick_result_t want);
    tick_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {we, be, bs};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    res = meter_tick(bs, be, act, we);
    pending_results.insert(pending_results.size(), typed ? want : res);
  endtask

  // Drop valid, wait out every pending result and let the sequencer go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WinBits-1:0] win);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= win;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_win = win;
  endtask

  function automatic time_t rand_stamp();
    return time_t'({$urandom, $urandom});
  endfunction

  // Pick a window length for a random segment, extremes in rotation
  function automatic logic [WinBits-1:0] segment_window(int unsigned seg);
    case (seg % 8)
      0: return WinBits'($urandom_range(20000, 1));
      1: return '0;
      2: return WinBits'(1);
      3: return WinBits'(999);
      4: return WinBits'(1000);
      5: return WinBits'(20000);
      6: return {WinBits{1'b1}};
      default: return WinBits'($urandom);
    endcase
  endfunction

  // One random tick: mostly an interval placed around the window, some noise
  task automatic random_tick();
    time_t       bs, be, we, tmp;
    int unsigned roll, reach;
    logic        act;
    roll  = $urandom_range(99);
    reach = 2 * model_win + 8;
    we    = rand_stamp();
    if ($urandom_range(99) < 15) we = time_t'($urandom_range(40000));
    if ($urandom_range(99) < 5)  we = MaxStamp - time_t'($urandom_range(100));
    if (roll < 70) begin
      bs = we - time_t'($urandom_range(reach));
      be = bs + time_t'($urandom_range(reach));
      if (roll < 8) begin
        tmp = bs; bs = be; be = tmp;   // reversed interval
      end
    end else begin
      bs = rand_stamp();
      be = rand_stamp();
    end
    act = 1'($urandom_range(1));
    send_tick(bs, be, act, we, 1'b0, '0);
  endtask

  // Receiver: check each accepted result, then pick next ready at random
  always @(posedge clk_i) begin
    tick_result_t got, exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{usage: m_axis_tdata[6:0], average: m_axis_tdata[13:7],
              report: m_axis_tuser[0]};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result usage %0d average %0d report %0d", $time,
                 got.usage, got.average, got.report);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          $display("%0t: expected usage %0d average %0d report %0d, got %0d %0d %0d",
                   $time, exp_res.usage, exp_res.average, exp_res.report,
                   got.usage, got.average, got.report);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("busy_window_utilization_meter verification failed");
      $finish;
    end
  end

  initial begin
    // Directed ticks; the first four start from reset with window_us 5000
    directed_rows = '{
      '{1'b0, 15'd0,     48'd0,                 48'd0,      1'b0, 48'd0,
        1'b1, '{7'd0,   7'd0,   1'b0}},
      '{1'b0, 15'd0,     48'd0,                 MaxStamp,   1'b0, 48'd10000,
        1'b1, '{7'd100, 7'd100, 1'b0}},
      '{1'b0, 15'd0,     48'd20000,             48'd30000,  1'b0, 48'd10000,
        1'b1, '{7'd0,   7'd50,  1'b0}},
      '{1'b0, 15'd0,     48'd8000,              48'd7000,   1'b0, 48'd10000,
        1'b1, '{7'd0,   7'd25,  1'b0}},
      '{1'b0, 15'd0,     48'd7500,              48'd0,      1'b1, 48'd10000, 1'b0, '0},
      '{1'b0, 15'd0,     48'd0,                 48'd500,    1'b0, 48'd1000,  1'b0, '0},
      '{1'b0, 15'd0,     MaxStamp - 48'd2500,   MaxStamp,   1'b0, MaxStamp,  1'b0, '0},
      '{1'b0, 15'd0,     MaxStamp,              MaxStamp,   1'b1, MaxStamp,  1'b0, '0},
      '{1'b0, 15'd0,     48'd0,                 48'd0,      1'b1, MaxStamp,  1'b0, '0},
      // empty window: covered end point gives full usage, no divide
      '{1'b1, 15'd0,     48'd5,                 48'd20,     1'b0, 48'd10,    1'b0, '0},
      '{1'b0, 15'd0,     48'd10,                48'd20,     1'b0, 48'd10,    1'b0, '0},
      '{1'b0, 15'd0,     48'd3,                 48'd9,      1'b0, 48'd10,    1'b0, '0},
      '{1'b1, 15'd1,     48'd9,                 48'd10,     1'b0, 48'd10,    1'b0, '0},
      // below one millisecond the count never moves
      '{1'b1, 15'd999,   48'd0,                 48'd500,    1'b0, 48'd2000,  1'b0, '0},
      '{1'b1, 15'h7FFF,  48'd0,                 MaxStamp,   1'b0, 48'd100000, 1'b0, '0},
      '{1'b1, 15'd20000, 48'd1000,              48'd2000,   1'b1, 48'd10000, 1'b0, '0},
      '{1'b1, 15'd1000,  48'd5,                 48'd10,     1'b0, 48'd20,    1'b0, '0}
    };

    model_win = WindowReset;
    model_avg = '0;
    model_ms  = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_win) begin
        settle();
        write_window(directed_rows[i].win);
      end
      send_tick(directed_rows[i].bstart, directed_rows[i].bend, directed_rows[i].active,
                directed_rows[i].wend, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random segments; the sender pauses for a full drain before each write
    for (int unsigned seg = 0; seg < SegCount; seg++) begin
      if (seg < SegCount / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 68;
      end else if (seg < 2 * SegCount / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      write_window(segment_window(seg));
      repeat (SegItems) random_tick();
    end

    settle();
    if (mismatches == 0) begin
      $display("busy_window_utilization_meter verification clean");
    end else begin
      $display("busy_window_utilization_meter verification failed");
    end
    $finish;
  end

endmodule

>>> busy_window_utilization_meter.f
hw/rtl/bwum_pkg.sv
hw/rtl/bwum_divider.sv
hw/rtl/busy_window_utilization_meter.sv
test/testbench.sv
